[sv/sem_undo_pkg.sv]
`timescale 1ns / 1ps

package sem_undo_pkg;

    localparam int KEY_W   = 24;
    localparam int TOTAL_W = 16;
    localparam int ENTRY_W = KEY_W + TOTAL_W;

    localparam logic [14:0] MAX_ADJUST_RESET  = 15'd16384;
    localparam logic [4:0]  MAX_ENTRIES_RESET = 5'd10;

    // Operation codes
    localparam logic OP_ADJUST  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic REG_MAX_ADJUST  = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               op;
        logic [5:0]         process;
        logic [15:0]        set_id;
        logic [7:0]         sem_number;
        logic signed [15:0] value;
    } undo_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] total;
        logic [4:0]         entry_count;
    } undo_result_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [TOTAL_W-1:0] total;
    } entry_t;

endpackage

[sv/sem_undo_ram.sv]
`timescale 1ns / 1ps

module sem_undo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/semaphore_undo_adjust_table.sv]
`timescale 1ns / 1ps

// Per-process adjust-on-exit table for semaphores.
// Input channel: drive item and raise start; the item is taken at a clock edge
// where start is high and busy is low. Op adjust moves the total of the entry
// keyed by (set_id, sem_number) by minus value; op release drops the process's
// undo structure and returns it to the pool.
// Output channel: every item gives exactly one result, shown on result for a
// single cycle with done high. The receiver cannot stall; it must take it then.
// Timing: done rises after the sorted search for an adjust, and after the
// per-process read for a release. busy then holds while the table shifts
// entries for an insert or a removal; a long search and a long shift exclude
// each other, and the next item is taken once busy falls.
// Configuration: write cfg_data to register cfg_index with cfg_we while idle.
// Reset: rst_n clears control state, loads the register defaults, and starts a
// clearing pass over the per-process memory with busy high. Entry memory
// contents are never cleared; only entries below a process's count are read.
module semaphore_undo_adjust_table #(
    parameter int PROCS        = 64,
    parameter int MAX_ENT      = 16,
    parameter int UNDO_STRUCTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sem_undo_pkg::undo_item_t   item,
    output logic                       done,
    output sem_undo_pkg::undo_result_t result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [14:0]                cfg_data
);

    import sem_undo_pkg::*;

    localparam int PROC_W  = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int IDX_W   = (MAX_ENT > 1) ? $clog2(MAX_ENT) : 1;
    localparam int CNT_W   = $clog2(MAX_ENT + 1);
    localparam int FREE_W  = $clog2(UNDO_STRUCTS + 1);
    localparam int EADDR_W = PROC_W + IDX_W;
    localparam int EDEPTH  = PROCS << IDX_W;
    localparam int PM_W    = CNT_W + 1;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_PROC   = 10'b0000000100,
        S_SEARCH = 10'b0000001000,
        S_DECIDE = 10'b0000010000,
        S_UP_RD  = 10'b0000100000,
        S_UP_WR  = 10'b0001000000,
        S_INSERT = 10'b0010000000,
        S_DN_RD  = 10'b0100000000,
        S_DN_WR  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [PROC_W-1:0]   clr_reg, clr_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [14:0]         max_adjust_reg;
    logic [4:0]          max_entries_reg;
    logic                done_reg, done_next;
    undo_result_t        result_reg, result_next;

    undo_item_t          item_reg, item_next;
    logic                has_reg, has_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic                found_reg, found_next;
    logic signed [15:0]  tot_reg, tot_next;

    // Per-process memory: {has structure, entry count}
    logic                pm_we;
    logic [PROC_W-1:0]   pm_waddr, pm_raddr;
    logic [PM_W-1:0]     pm_wdata, pm_rdata;

    // Entry memory: PROCS rows of MAX_ENT sorted entries
    logic                em_we;
    logic [EADDR_W-1:0]  em_waddr, em_raddr;
    logic [ENTRY_W-1:0]  em_wdata, em_rdata;

    logic [PROC_W-1:0]   proc_idx;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    cap;
    logic signed [16:0]  val_x, lim_x, nt;
    logic signed [15:0]  neg_val;
    entry_t              rd_entry;
    logic [CNT_W-1:0]    idx_inc, jm1, jp1;

    sem_undo_ram #(
        .WIDTH (PM_W),
        .DEPTH (PROCS)
    ) u_proc_ram (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    sem_undo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EDEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    assign proc_idx = PROC_W'(item_reg.process);
    assign key      = {item_reg.set_id, item_reg.sem_number};
    assign cap      = (32'(max_entries_reg) > MAX_ENT) ? CNT_W'(MAX_ENT)
                                                       : CNT_W'(max_entries_reg);
    assign val_x    = {item_reg.value[15], item_reg.value};
    assign lim_x    = signed'({2'b00, max_adjust_reg});
    assign nt       = {tot_reg[15], tot_reg} - val_x;
    assign neg_val  = 16'(-val_x);
    assign rd_entry = entry_t'(em_rdata);
    assign idx_inc  = idx_reg + 1'b1;
    assign jm1      = j_reg - 1'b1;
    assign jp1      = j_reg + 1'b1;

    always_comb
    begin
        logic             val_bad;
        logic             take;
        logic [CNT_W-1:0] cnt_eff;
        logic [CNT_W-1:0] idx_eff;
        logic             found_eff;

        val_bad   = 1'b0;
        take      = 1'b0;
        cnt_eff   = cnt_reg;
        idx_eff   = idx_reg;
        found_eff = found_reg;

        state_next  = state_reg;
        clr_next    = clr_reg;
        free_next   = free_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        item_next   = item_reg;
        has_next    = has_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        found_next  = found_reg;
        tot_next    = tot_reg;

        pm_we    = 1'b0;
        pm_waddr = proc_idx;
        pm_wdata = '0;
        pm_raddr = '0;
        em_we    = 1'b0;
        em_waddr = {proc_idx, idx_reg[IDX_W-1:0]};
        em_wdata = entry_t'{key: key, total: neg_val};
        em_raddr = {proc_idx, idx_reg[IDX_W-1:0]};

        case (state_reg)
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                pm_wdata = '0;
                if (clr_reg == PROC_W'(PROCS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (32'(item.process) >= PROCS)
                    begin
                        // process outside the table: answer all zero
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        pm_raddr   = PROC_W'(item.process);
                        state_next = S_PROC;
                    end
                end
            end

            S_PROC:
            begin
                if (item_reg.op == OP_RELEASE)
                begin
                    if (pm_rdata[CNT_W])
                    begin
                        pm_we    = 1'b1;
                        pm_wdata = '0;
                        if (32'(free_reg) < UNDO_STRUCTS)
                        begin
                            free_next = free_reg + 1'b1;
                        end
                    end
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    has_next   = pm_rdata[CNT_W];
                    cnt_next   = pm_rdata[CNT_W] ? pm_rdata[CNT_W-1:0] : '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    tot_next   = '0;
                    if (pm_rdata[CNT_W] && (pm_rdata[CNT_W-1:0] != '0))
                    begin
                        em_raddr   = {proc_idx, {IDX_W{1'b0}}};
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_SEARCH:
            begin
                if (rd_entry.key < key)
                begin
                    idx_next = idx_inc;
                    if (idx_inc == cnt_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        em_raddr = {proc_idx, idx_inc[IDX_W-1:0]};
                    end
                end
                else
                begin
                    found_next = (rd_entry.key == key);
                    tot_next   = rd_entry.total;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                val_bad    = (val_x > lim_x) || (val_x < -lim_x);
                state_next = S_IDLE;
                done_next  = 1'b1;
                if ((val_x == 17'sd0) || val_bad)
                begin
                    result_next.status      = val_bad ? ST_RANGE : ST_OK;
                    result_next.total       = found_reg ? tot_reg : 16'sd0;
                    result_next.entry_count = 5'(cnt_reg);
                end
                else if (!has_reg && (free_reg == '0))
                begin
                    result_next.status      = ST_NO_SPACE;
                    result_next.total       = '0;
                    result_next.entry_count = '0;
                end
                else
                begin
                    if (!has_reg)
                    begin
                        // take a structure from the pool
                        take      = 1'b1;
                        free_next = free_reg - 1'b1;
                        cnt_eff   = '0;
                        idx_eff   = '0;
                        found_eff = 1'b0;
                    end
                    idx_next = idx_eff;
                    if (!found_eff)
                    begin
                        if (cnt_eff >= cap)
                        begin
                            // table full; a freshly taken structure stays
                            pm_we    = take;
                            pm_wdata = {1'b1, {CNT_W{1'b0}}};
                            result_next.status      = ST_FULL;
                            result_next.total       = '0;
                            result_next.entry_count = 5'(cnt_eff);
                        end
                        else
                        begin
                            pm_we    = 1'b1;
                            pm_wdata = {1'b1, cnt_eff + 1'b1};
                            result_next.status      = ST_OK;
                            result_next.total       = neg_val;
                            result_next.entry_count = 5'(cnt_eff + 1'b1);
                            j_next     = cnt_eff;
                            state_next = (cnt_eff > idx_eff) ? S_UP_RD : S_INSERT;
                        end
                    end
                    else if ((nt > lim_x) || (nt < -lim_x))
                    begin
                        result_next.status      = ST_RANGE;
                        result_next.total       = tot_reg;
                        result_next.entry_count = 5'(cnt_reg);
                    end
                    else if (nt == 17'sd0)
                    begin
                        // drop the entry and close the gap
                        pm_we    = 1'b1;
                        pm_wdata = {1'b1, cnt_reg - 1'b1};
                        result_next.status      = ST_OK;
                        result_next.total       = '0;
                        result_next.entry_count = 5'(cnt_reg - 1'b1);
                        j_next = idx_reg;
                        if (({1'b0, idx_reg} + 1'b1) < {1'b0, cnt_reg})
                        begin
                            state_next = S_DN_RD;
                        end
                    end
                    else
                    begin
                        em_we    = 1'b1;
                        em_wdata = entry_t'{key: key, total: 16'(nt)};
                        result_next.status      = ST_OK;
                        result_next.total       = 16'(nt);
                        result_next.entry_count = 5'(cnt_reg);
                    end
                end
            end

            S_UP_RD:
            begin
                em_raddr   = {proc_idx, jm1[IDX_W-1:0]};
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                em_we    = 1'b1;
                em_waddr = {proc_idx, j_reg[IDX_W-1:0]};
                em_wdata = em_rdata;
                j_next   = jm1;
                state_next = (jm1 == idx_reg) ? S_INSERT : S_UP_RD;
            end

            S_INSERT:
            begin
                em_we      = 1'b1;
                em_waddr   = {proc_idx, idx_reg[IDX_W-1:0]};
                em_wdata   = entry_t'{key: key, total: neg_val};
                state_next = S_IDLE;
            end

            S_DN_RD:
            begin
                em_raddr   = {proc_idx, jp1[IDX_W-1:0]};
                state_next = S_DN_WR;
            end

            S_DN_WR:
            begin
                em_we    = 1'b1;
                em_waddr = {proc_idx, j_reg[IDX_W-1:0]};
                em_wdata = em_rdata;
                j_next   = jp1;
                if (({1'b0, jp1} + 1'b1) < {1'b0, cnt_reg})
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            free_reg        <= FREE_W'(UNDO_STRUCTS);
            done_reg        <= 1'b0;
            max_adjust_reg  <= MAX_ADJUST_RESET;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ADJUST:  max_adjust_reg  <= cfg_data;
                    REG_MAX_ENTRIES: max_entries_reg <= cfg_data[4:0];
                    default:         max_adjust_reg  <= max_adjust_reg;
                endcase
            end
        end
    end

    // Payload: hold the item and the walk context
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        item_reg   <= item_next;
        has_reg    <= has_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        found_reg  <= found_next;
        tot_reg    <= tot_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/sem_undo_checker.sv]
`timescale 1ns / 1ps

module sem_undo_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input sem_undo_pkg::undo_result_t result
);

    import sem_undo_pkg::*;

    // an accepted item either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor answered");

    // a result only follows an accept or busy work
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without an item in flight");

    a_no_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_NO_SPACE)) |->
            ((result.total == 16'sd0) && (result.entry_count == 5'd0)))
        else $error("no-space result carries a total or count");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.total == 16'sd0))
        else $error("table-full result carries a total");

endmodule

bind semaphore_undo_adjust_table sem_undo_checker u_sem_undo_checker (.*);

[tb/semaphore_undo_adjust_table_test.sv]
`timescale 1ns / 1ps

module semaphore_undo_adjust_table_test;
    import sem_undo_pkg::*;

    localparam int PROCS        = 64;
    localparam int MAX_ENT      = 16;
    localparam int UNDO_STRUCTS = 32;

    // Longest time one item keeps the block busy, plus some margin.
    localparam int SETTLE_CYCLES = 4 + 3 * MAX_ENT + 8;
    localparam int IDLE_PCT      = 16;
    // Offer items back to back, without random gaps, over this window.
    localparam int STEADY_FIRST  = 300;
    localparam int STEADY_LAST   = 420;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CONFIG,
        STEP_DRAIN
    } step_kind_t;

    // One entry of the driver's work list: an item to offer, a register
    // write, or a pause until every outstanding result has come back.
    typedef struct packed {
        step_kind_t  kind;
        undo_item_t  item;
        logic        cfg_reg;
        logic [14:0] cfg_value;
    } step_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    logic         busy;
    undo_item_t   item      = '0;
    logic         done;
    undo_result_t result;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = REG_MAX_ADJUST;
    logic [14:0]  cfg_data  = '0;

    step_t        pending_steps[$];
    undo_result_t expected_results[$];
    bit           item_taken     = 1'b0;
    int           errors         = 0;
    int           items_offered  = 0;
    int           items_accepted = 0;
    int           settings_used  = 1;
    int           status_seen[4];

    // Shadow copy of the per-process undo tables and the shared pool.
    logic [23:0]  tbl_key   [PROCS][MAX_ENT];
    int           tbl_total [PROCS][MAX_ENT];
    int           tbl_count [PROCS];
    bit           owns_struct [PROCS];
    int           pool_free   = UNDO_STRUCTS;
    int           lim_adjust  = int'(MAX_ADJUST_RESET);
    int           cap_entries = int'(MAX_ENTRIES_RESET);

    semaphore_undo_adjust_table #(
        .PROCS        (PROCS),
        .MAX_ENT      (MAX_ENT),
        .UNDO_STRUCTS (UNDO_STRUCTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Apply one accepted item to the shadow tables and return the result
    // the block must give for it.
    function automatic undo_result_t predict_undo(undo_item_t it);
        undo_result_t r;
        int           p;
        int           val;
        int           cap;
        int           cnt;
        int           i;
        int           j;
        int           nt;
        logic [23:0]  key;
        bit           found;
        r     = '0;
        p     = it.process;
        key   = {it.set_id, it.sem_number};
        val   = $signed(it.value);
        cap   = (cap_entries > MAX_ENT) ? MAX_ENT : cap_entries;
        found = 1'b0;

        // A release drops the table and hands the structure back, if any.
        if (it.op == OP_RELEASE)
        begin
            if (owns_struct[p])
            begin
                owns_struct[p] = 1'b0;
                tbl_count[p]   = 0;
                if (pool_free < UNDO_STRUCTS)
                    pool_free++;
            end
            return r;
        end

        // Walk the sorted table up to the first key not below the target.
        cnt = owns_struct[p] ? tbl_count[p] : 0;
        for (i = 0; i < cnt; i++)
        begin
            if (tbl_key[p][i] >= key)
            begin
                found = (tbl_key[p][i] == key);
                break;
            end
        end

        // Zero or over-limit values only report what is already there.
        if (val == 0 || val > lim_adjust || val < -lim_adjust)
        begin
            r.status      = (val == 0) ? ST_OK : ST_RANGE;
            r.total       = found ? 16'(tbl_total[p][i]) : '0;
            r.entry_count = 5'(cnt);
            return r;
        end

        // Take a structure from the pool on first use.
        if (!owns_struct[p])
        begin
            if (pool_free == 0)
            begin
                r.status = ST_NO_SPACE;
                return r;
            end
            pool_free--;
            owns_struct[p] = 1'b1;
            tbl_count[p]   = 0;
            cnt            = 0;
            i              = 0;
            found          = 1'b0;
        end

        // New key: open a slot at the sorted position, unless the table is full.
        if (!found)
        begin
            if (cnt >= cap)
            begin
                r.status      = ST_FULL;
                r.entry_count = 5'(cnt);
                return r;
            end
            for (j = cnt; j > i; j--)
            begin
                tbl_key[p][j]   = tbl_key[p][j - 1];
                tbl_total[p][j] = tbl_total[p][j - 1];
            end
            tbl_key[p][i]   = key;
            tbl_total[p][i] = -val;
            tbl_count[p]    = cnt + 1;
            r.total         = 16'(-val);
            r.entry_count   = 5'(cnt + 1);
            return r;
        end

        // Existing key: move the total, drop the entry when it reaches zero.
        nt            = tbl_total[p][i] - val;
        r.entry_count = 5'(cnt);
        if (nt > lim_adjust || nt < -lim_adjust)
        begin
            r.status = ST_RANGE;
            r.total  = 16'(tbl_total[p][i]);
        end
        else if (nt == 0)
        begin
            for (j = i; j + 1 < cnt; j++)
            begin
                tbl_key[p][j]   = tbl_key[p][j + 1];
                tbl_total[p][j] = tbl_total[p][j + 1];
            end
            tbl_count[p]  = cnt - 1;
            r.entry_count = 5'(cnt - 1);
        end
        else
        begin
            tbl_total[p][i] = nt;
            r.total         = 16'(nt);
        end
        return r;
    endfunction

    // Random adjust or release. Most items hit a few busy processes and a
    // small set of keys so that tables fill, totals cancel and entries go
    // away; the rest spread over every process and the whole key space.
    function automatic undo_item_t random_item(int lim);
        undo_item_t it;
        int         pick;
        int         mag;
        it.op      = ($urandom_range(99) < 6) ? OP_RELEASE : OP_ADJUST;
        it.process = ($urandom_range(99) < 70) ? 6'($urandom_range(7))
                                               : 6'($urandom_range(63));
        if ($urandom_range(99) < 80)
        begin
            case ($urandom_range(3))
                0:       it.set_id = 16'h0000;
                1:       it.set_id = 16'h0001;
                2:       it.set_id = 16'h8000;
                default: it.set_id = 16'hFFFF;
            endcase
            it.sem_number = 8'($urandom_range(5));
        end
        else
        begin
            it.set_id     = 16'($urandom);
            it.sem_number = 8'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 8)
            mag = 0;
        else if (pick < 78)
            mag = $urandom_range(4, 1);
        else if (pick < 90)
            mag = lim + $urandom_range(1);      // right at the limit or one past
        else
            mag = $urandom_range(32768);
        it.value = 16'($urandom_range(1) ? mag : -mag);
        return it;
    endfunction

    task automatic add_item(logic op, int proc, int set, int sem, int val);
        step_t s;
        s                 = '0;
        s.kind            = STEP_ITEM;
        s.item.op         = op;
        s.item.process    = 6'(proc);
        s.item.set_id     = 16'(set);
        s.item.sem_number = 8'(sem);
        s.item.value      = 16'(val);
        pending_steps.push_back(s);
    endtask

    task automatic add_control(step_kind_t kind, logic reg_sel, int value);
        step_t s;
        s           = '0;
        s.kind      = kind;
        s.cfg_reg   = reg_sel;
        s.cfg_value = 15'(value);
        pending_steps.push_back(s);
    endtask

    // New register setting: both registers, written once the block is idle.
    task automatic add_setting(int lim, int cap);
        add_control(STEP_CONFIG, REG_MAX_ADJUST, lim);
        add_control(STEP_CONFIG, REG_MAX_ENTRIES, cap);
        settings_used++;
    endtask

    task automatic add_random(int count, int lim);
        step_t s;
        int    k;
        for (k = 0; k < count; k++)
        begin
            s      = '0;
            s.kind = STEP_ITEM;
            s.item = random_item(lim);
            pending_steps.push_back(s);
            // Now and then hold the sender until the block has answered everything.
            if (k % 97 == 96)
                add_control(STEP_DRAIN, REG_MAX_ADJUST, 0);
        end
    endtask

    // Driver: change inputs on the falling edge only. Hold start and the item
    // until the block takes it; register writes and pauses wait until no
    // result is outstanding and busy is low.
    always @(negedge clk)
    begin : driver
        logic nxt_start;
        logic nxt_we;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (rst_n && !(start && !item_taken))
        begin
            nxt_start = 1'b0;
            if (pending_steps.size() != 0)
            begin
                case (pending_steps[0].kind)
                    STEP_ITEM:
                    begin
                        if ((items_offered >= STEADY_FIRST && items_offered < STEADY_LAST)
                            || $urandom_range(99) >= IDLE_PCT)
                        begin
                            nxt_start = 1'b1;
                            item <= pending_steps[0].item;
                            items_offered++;
                            void'(pending_steps.pop_front());
                        end
                    end
                    default:
                    begin
                        if (expected_results.size() == 0 && !busy)
                        begin
                            if (pending_steps[0].kind == STEP_CONFIG)
                            begin
                                nxt_we = 1'b1;
                                cfg_index <= pending_steps[0].cfg_reg;
                                cfg_data  <= pending_steps[0].cfg_value;
                            end
                            void'(pending_steps.pop_front());
                        end
                    end
                endcase
            end
        end
        start  <= nxt_start;
        cfg_we <= nxt_we;
    end

    // Monitor: on the rising edge, check a finished result against the oldest
    // prediction first, then track register writes and newly taken items.
    always @(posedge clk)
    begin : monitor
        undo_result_t want;
        item_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                status_seen[result.status]++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none,", $time,
                             " actual status %0d total %0d count %0d",
                             result.status, result.total, result.entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status || result.total !== want.total
                        || result.entry_count !== want.entry_count)
                    begin
                        errors++;
                        $display("%0t: mismatch,", $time,
                                 " expected status %0d total %0d count %0d,",
                                 want.status, want.total, want.entry_count,
                                 " actual status %0d total %0d count %0d",
                                 result.status, result.total, result.entry_count);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_ADJUST)
                    lim_adjust = int'(cfg_data);
                else
                    cap_entries = int'(cfg_data[4:0]);
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_undo(item));
                items_accepted++;
            end
        end
    end

    initial
    begin : stimulus
        int lim;
        int k;
        lim = int'(MAX_ADJUST_RESET);

        // Directed part at the reset settings.
        add_item(OP_ADJUST, 0, 0, 0, 0);                // zero value, no structure yet
        add_item(OP_ADJUST, 0, 0, 0, lim);              // exactly at the limit
        add_item(OP_ADJUST, 0, 0, 0, 1);                // total would leave the limit
        add_item(OP_ADJUST, 0, 0, 0, lim + 1);          // value just past the limit
        add_item(OP_ADJUST, 0, 0, 0, -32768);
        add_item(OP_ADJUST, 0, 0, 0, 32767);
        add_item(OP_ADJUST, 0, 0, 0, 0);                // zero value reports the total
        add_item(OP_ADJUST, 0, 0, 0, -lim);             // total cancels, entry goes away
        add_item(OP_ADJUST, 63, 16'hFFFF, 8'hFF, -1);
        add_item(OP_ADJUST, 63, 0, 0, 5);               // insert ahead of everything
        add_item(OP_ADJUST, 63, 16'hFFFF, 0, 3);        // insert in the middle
        add_item(OP_RELEASE, 63, 0, 0, 0);
        add_item(OP_RELEASE, 5, 16'h5A5A, 8'hA5, 7);    // release without a structure
        add_item(OP_ADJUST, 63, 16'h1234, 8'h56, 2);    // table restarts after release
        // Fill one table in reverse key order, one past the entry limit.
        for (k = 10; k >= 0; k--)
            add_item(OP_ADJUST, 1, k, 0, 1);

        add_setting(32767, MAX_ENT);
        add_random(250, 32767);
        add_setting(0, 1);                              // every nonzero value is out of range
        add_random(15, 0);
        add_setting(6, 1);
        add_random(100, 6);
        add_setting(40, 0);                             // no entry fits, structures are kept
        add_random(12, 40);
        add_setting(16384, 31);                         // above the table depth
        add_random(200, 16384);
        lim = $urandom_range(60, 5);
        add_setting(lim, 5);
        add_random(130, lim);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and answered, then let the
        // last table shift finish.
        while (pending_steps.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d items over %0d register settings.", items_accepted,
                 settings_used);
        $display("Results by status: ok %0d, range %0d, no structure %0d, table full %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_NO_SPACE],
                 status_seen[ST_FULL]);
        if (errors == 0)
            $display("PASS semaphore_undo_adjust_table");
        else
            $display("FAIL semaphore_undo_adjust_table");
        $finish;
    end

    // Watchdog well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL semaphore_undo_adjust_table");
        $finish;
    end

endmodule

[sim.f]
sv/sem_undo_pkg.sv
sv/sem_undo_ram.sv
sv/semaphore_undo_adjust_table.sv
sv/sem_undo_checker.sv
tb/semaphore_undo_adjust_table_test.sv
